// File: hw/rtl/range_minimum_segment_tree_core_assert.svh
// Assertion macros for the range-minimum tree core.
// Used by the sequencer. Expects clk_i and rst_ni in the including scope.
`ifndef RANGE_MINIMUM_SEGMENT_TREE_CORE_ASSERT_SVH
`define RANGE_MINIMUM_SEGMENT_TREE_CORE_ASSERT_SVH

`ifndef SYNTH
`define RMST_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define RMST_ASSERT_IMPLY(lbl, ante, cons)
`endif

`ifndef SYNTH
`define RMST_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("assertion failed");
`else
`define RMST_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: hw/rtl/rmst_pkg.sv
// Shared constants, types and helpers for the range-minimum tree core.
// No dependencies.
`default_nettype none

package rmst_pkg;

  localparam int unsigned LEAVES     = 1024;
  localparam int unsigned LEAF_W     = $clog2(LEAVES);
  localparam int unsigned NODE_AW    = LEAF_W + 1;   // node address, heap order
  localparam int unsigned POS_W      = LEAF_W + 2;   // 1-based position, holds 2*LEAVES
  localparam int unsigned NODE_DEPTH = 2 * LEAVES;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SLOT_W     = 11;
  localparam int unsigned OPC_W      = 2;

  localparam logic [DATA_W-1:0] NODE_TOP = 32'h7FFF_FFFF;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    logic [DATA_W-1:0]  wdata;
    logic               re;
    logic [NODE_AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
  } res_t;

  function automatic logic [DATA_W-1:0] node_min(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    return ($signed(a) <= $signed(b)) ? a : b;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rmst_node_ram.sv
// Node store: one write port, one read port, registered read data.
// Depends on rmst_pkg.
`default_nettype none

module rmst_node_ram (
  input  wire                     clk_i,
  input  rmst_pkg::ram_req_t      req_i,
  output logic [rmst_pkg::DATA_W-1:0] rdata_o
);
  import rmst_pkg::*;

  logic [DATA_W-1:0] mem [NODE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rmst_seq.sv
// Sequencer: clear sweep, leaf-to-root update, bottom-up range query.
// Depends on rmst_pkg and the assertion macro header.
`default_nettype none
`include "range_minimum_segment_tree_core_assert.svh"

module rmst_seq (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  rmst_pkg::op_e                in_opcode_i,
  input  wire [rmst_pkg::SLOT_W-1:0]   in_slot_i,
  input  wire [rmst_pkg::DATA_W-1:0]   in_value_i,
  input  wire                          out_free_i,
  output rmst_pkg::res_t               res_o,
  output rmst_pkg::ram_req_t           req_o,
  input  wire [rmst_pkg::DATA_W-1:0]   rdata_i
);
  import rmst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_UPD_RD,
    S_UPD_WR,
    S_QL,
    S_QR,
    S_QS,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [NODE_AW-1:0] clr_q, clr_d;
  logic               clr_item_q, clr_item_d;
  logic [NODE_AW-1:0] k_q, k_d;
  logic [DATA_W-1:0]  cur_q, cur_d;
  logic [POS_W-1:0]   l_q, l_d, r_q, r_d;
  logic               pend_q, pend_d;
  logic [DATA_W-1:0]  res_q, res_d;

  logic [DATA_W-1:0]  acc;
  logic [DATA_W-1:0]  hi_ext;
  logic [LEAF_W:0]    hi;
  logic               q_empty;
  logic [POS_W-1:0]   q_l, q_r;
  logic [NODE_AW-1:0] leaf_pos;
  logic               q_walk;

  // fold in the node read issued last cycle
  assign acc = pend_q ? node_min(res_q, rdata_i) : res_q;

  assign q_walk = (state_q == S_QL) || (state_q == S_QR) || (state_q == S_QS);

  // query bounds: negative left is 0, right clamps to the leaf count
  always_comb begin
    hi_ext  = (DATA_W'(in_slot_i) > DATA_W'(LEAVES)) ? DATA_W'(LEAVES) : DATA_W'(in_slot_i);
    hi      = hi_ext[LEAF_W:0];
    q_empty = in_value_i[DATA_W-1] ? (hi_ext == '0) : (in_value_i >= hi_ext);
    q_l     = (in_value_i[DATA_W-1] ? '0 : POS_W'(in_value_i[LEAF_W:0])) + POS_W'(LEAVES);
    q_r     = POS_W'(hi) + POS_W'(LEAVES);
    leaf_pos = NODE_AW'(in_slot_i) + NODE_AW'(LEAVES);
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    clr_item_d = clr_item_q;
    k_d        = k_q;
    cur_d      = cur_q;
    l_d        = l_q;
    r_d        = r_q;
    pend_d     = 1'b0;
    res_d      = acc;
    req_o      = '0;
    res_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_opcode_i)
            OP_CLEAR: begin
              res_d      = '0;
              clr_d      = '0;
              clr_item_d = 1'b1;
              state_d    = S_CLR;
            end
            OP_UPDATE: begin
              res_d = '0;
              if (DATA_W'(in_slot_i) < DATA_W'(LEAVES)) begin
                req_o.we    = 1'b1;
                req_o.waddr = leaf_pos - NODE_AW'(1);
                req_o.wdata = in_value_i;
                cur_d       = in_value_i;
                k_d         = leaf_pos;
                state_d     = S_UPD_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            OP_QUERY: begin
              res_d   = NODE_TOP;
              l_d     = q_l;
              r_d     = q_r;
              state_d = q_empty ? S_DONE : S_QL;
            end
            default: begin
              res_d   = '0;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CLR: begin
        req_o.we    = 1'b1;
        req_o.waddr = clr_q;
        req_o.wdata = NODE_TOP;
        clr_d       = clr_q + NODE_AW'(1);
        if (clr_q == NODE_AW'(NODE_DEPTH - 1)) begin
          state_d = clr_item_q ? S_DONE : S_IDLE;
        end
      end
      S_UPD_RD: begin
        if (k_q == NODE_AW'(1)) begin
          state_d = S_DONE;
        end else begin
          // fetch the sibling, then step up to the parent
          req_o.re    = 1'b1;
          req_o.raddr = (k_q ^ NODE_AW'(1)) - NODE_AW'(1);
          k_d         = k_q >> 1;
          state_d     = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        cur_d       = node_min(cur_q, rdata_i);
        req_o.we    = 1'b1;
        req_o.waddr = k_q - NODE_AW'(1);
        req_o.wdata = cur_d;
        state_d     = S_UPD_RD;
      end
      S_QL: begin
        if (l_q >= r_q) begin
          state_d = S_DONE;
        end else begin
          if (l_q[0]) begin
            req_o.re    = 1'b1;
            req_o.raddr = NODE_AW'(l_q - POS_W'(1));
            pend_d      = 1'b1;
            l_d         = l_q + POS_W'(1);
          end
          state_d = S_QR;
        end
      end
      S_QR: begin
        if (r_q[0]) begin
          r_d         = r_q - POS_W'(1);
          req_o.re    = 1'b1;
          req_o.raddr = NODE_AW'(r_q - POS_W'(2));
          pend_d      = 1'b1;
        end
        state_d = S_QS;
      end
      S_QS: begin
        l_d     = l_q >> 1;
        r_d     = r_q >> 1;
        state_d = S_QL;
      end
      S_DONE: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.value = acc;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // reset starts with a sweep that fills every node with the top value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      clr_item_q <= 1'b0;
      k_q        <= '0;
      cur_q      <= '0;
      l_q        <= '0;
      r_q        <= '0;
      pend_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clr_item_q <= clr_item_d;
      k_q        <= k_d;
      cur_q      <= cur_d;
      l_q        <= l_d;
      r_q        <= r_d;
      pend_q     <= pend_d;
      res_q      <= res_d;
    end
  end

  `RMST_ASSERT_NEVER(a_no_rw_same_entry, req_o.we && req_o.re && req_o.waddr == req_o.raddr)
  `RMST_ASSERT_IMPLY(a_query_bounds_ordered, q_walk, l_q <= r_q)
  `RMST_ASSERT_IMPLY(a_pend_follows_read, pend_q, $past(req_o.re))

endmodule

`default_nettype wire

// File: hw/rtl/range_minimum_segment_tree_core.sv
// Range-minimum segment tree core: stream ports, result register.
// Depends on rmst_pkg, rmst_node_ram and rmst_seq.
`default_nettype none

// Min-tree over 1024 signed 32-bit leaves, kept in a single 2048-entry node
// RAM with one read and one write port. Each input item carries an opcode in
// tuser: clear, point update, or range-minimum query over [left, right).
// Every item yields exactly one result item (the minimum for a query, zero
// otherwise). After reset and after each clear item the core sweeps the RAM,
// accepting nothing. An update walks from the leaf to the root with a sibling
// read and a parent write per tree level; a query walks the bounds bottom-up
// with a left read, a right read and a shift per level pair step. One item is
// in work at a time; the result register lets the next item be accepted while
// a result still waits on the output.
module range_minimum_segment_tree_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // [10:0] slot_or_right, [42:11] value_or_left
  input  wire  [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] min_value
);
  import rmst_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  res_t              res;
  logic              out_free;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;

  assign out_free = !out_valid_q || m_axis_tready;

  rmst_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  rmst_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (op_e'(s_axis_tuser)),
    .in_slot_i   (s_axis_tdata[SLOT_W-1:0]),
    .in_value_i  (s_axis_tdata[SLOT_W+DATA_W-1:SLOT_W]),
    .out_free_i  (out_free),
    .res_o       (res),
    .req_o       (ram_req),
    .rdata_i     (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res.value;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: sim/range_minimum_segment_tree_core_tb.sv
// Self-checking testbench for range_minimum_segment_tree_core.
// Keeps its own min-tree, predicts each result and checks the output stream.
// Depends on rmst_pkg and the core RTL.

module range_minimum_segment_tree_core_tb;
  import rmst_pkg::*;

  localparam int unsigned PAD          = 1 << $clog2(LEAVES);
  localparam int unsigned N_ITEMS      = 1700;
  localparam int unsigned CALM_TAIL    = 200;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [1:0]  OP_RESERVED  = 2'd3;

  typedef struct packed {
    logic [1:0]  opc;
    logic [10:0] slot;   // leaf index, or exclusive right bound
    logic [31:0] arg;    // leaf value, or inclusive left bound
  } tree_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [10:0] slot_or_right, [42:11] value_or_left
  logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] min_value

  range_minimum_segment_tree_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tree_cmd_t          cmd_q[$];
  logic [31:0]        min_expect_q[$];
  logic signed [31:0] tree_q [0:2*PAD-2];

  int  n_total;
  int  n_in;
  int  n_out;
  int  n_bad;
  int  n_upd, n_qry, n_clr, n_rsv;
  int  gap_left;
  int  stall_left;
  bit  item_taken;
  bit  hold_off;
  bit  rdy_n;
  tree_cmd_t cur;

  // Random idling only away from the tail, and with quiet stretches in between.
  function automatic bit noisy();
    return (n_in + CALM_TAIL < n_total) && ((n_in / 150) % 3 != 2);
  endfunction

  // Applies one item to the local tree and returns the expected min_value.
  function automatic logic [31:0] tree_step(input logic [1:0] opc, input logic [10:0] slot,
                                            input logic [31:0] arg);
    int unsigned        k, lo, hi, l, r;
    logic signed [31:0] best;
    best = NODE_TOP;
    case (opc)
      OP_CLEAR: begin
        for (int i = 0; i < 2 * PAD - 1; i++) tree_q[i] = NODE_TOP;
        return '0;
      end
      OP_UPDATE: begin
        if (slot >= PAD) return '0;
        k = slot + PAD - 1;
        tree_q[k] = arg;
        while (k > 0) begin
          k = (k - 1) / 2;
          tree_q[k] = (tree_q[2*k+1] <= tree_q[2*k+2]) ? tree_q[2*k+1] : tree_q[2*k+2];
        end
        return '0;
      end
      OP_QUERY: begin
        lo = arg[31] ? 0 : arg;
        hi = (slot > PAD) ? PAD : slot;
        if (lo >= hi) return NODE_TOP;
        // bottom-up walk on 1-based heap positions
        l = lo + PAD;
        r = hi + PAD;
        while (l < r) begin
          if (l[0]) begin
            if (tree_q[l-1] < best) best = tree_q[l-1];
            l++;
          end
          if (r[0]) begin
            r--;
            if (tree_q[r-1] < best) best = tree_q[r-1];
          end
          l = l >> 1;
          r = r >> 1;
        end
        return best;
      end
      default: return '0;
    endcase
  endfunction

  task automatic push_cmd(input logic [1:0] opc, input logic [10:0] slot,
                          input logic [31:0] arg);
    tree_cmd_t c;
    c.opc  = opc;
    c.slot = slot;
    c.arg  = arg;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return NODE_TOP;
      2, 3:    return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [10:0] pick_slot();
    case ($urandom_range(0, 15))
      0:          return 11'($urandom_range(LEAVES, 2047));
      1, 2, 3, 4: return 11'($urandom_range(0, 63));
      default:    return 11'($urandom_range(0, LEAVES - 1));
    endcase
  endfunction

  // ---- sender ----
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || item_taken)) begin
      item_taken = 1'b0;
      if (gap_left != 0 || cmd_q.size() == 0) begin
        if (gap_left != 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        cur = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, cur.arg, cur.slot};
        s_axis_tuser  <= cur.opc;
        if (noisy() && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 15);
      end
    end
  end

  // accepted items feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      min_expect_q.insert(min_expect_q.size(),
                          tree_step(s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[42:11]));
      case (s_axis_tuser)
        OP_CLEAR:  n_clr++;
        OP_UPDATE: n_upd++;
        OP_QUERY:  n_qry++;
        default:   n_rsv++;
      endcase
      n_in++;
      item_taken = 1'b1;
    end
  end

  // ---- receiver ----
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      rdy_n = 1'b0;
    end else begin
      rdy_n = 1'b1;
      if (noisy() && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 15);
    end
    m_axis_tready <= rdy_n && !hold_off;
  end

  // long back-pressure so the core fills up and stalls its input
  initial begin
    hold_off = 1'b0;
    wait (n_in >= HOLD_AT);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_out++;
      if (min_expect_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("result %0d with nothing pending: got %0d", n_out, $signed(m_axis_tdata));
      end else if (m_axis_tdata !== min_expect_q[0]) begin
        n_bad++;
        if (n_bad <= 10)
          $display("min_value on result %0d: expected %0d, got %0d", n_out,
                   $signed(min_expect_q[0]), $signed(m_axis_tdata));
        void'(min_expect_q.pop_front());
      end else begin
        void'(min_expect_q.pop_front());
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("range_minimum_segment_tree_core: mismatch");
    $finish;
  end

  initial begin
    int          lft, rgt;
    logic [31:0] lft_bits;
    n_in = 0; n_out = 0; n_bad = 0;
    n_upd = 0; n_qry = 0; n_clr = 0; n_rsv = 0;
    gap_left = 0; stall_left = 0; item_taken = 1'b0;
    for (int i = 0; i < 2 * PAD - 1; i++) tree_q[i] = NODE_TOP;

    // directed: extremes, clamping, empty ranges, ignored writes, reserved opcode
    push_cmd(OP_QUERY,  11'd1024, 32'd0);            // untouched tree
    push_cmd(OP_UPDATE, 11'd0,    32'h8000_0000);
    push_cmd(OP_UPDATE, 11'd1023, NODE_TOP);
    push_cmd(OP_UPDATE, 11'd1023, 32'hFFFF_FFFF);
    push_cmd(OP_UPDATE, 11'd1024, 32'hFFFF_FFFB);    // slot out of range
    push_cmd(OP_UPDATE, 11'd2047, 32'd0);            // slot out of range
    push_cmd(OP_QUERY,  11'd1024, 32'd0);
    push_cmd(OP_QUERY,  11'd1024, 32'd1);
    push_cmd(OP_QUERY,  11'd1,    32'hFFFF_FFF9);    // negative left
    push_cmd(OP_QUERY,  11'd2047, 32'd1000);         // right clamped
    push_cmd(OP_QUERY,  11'd5,    32'd5);            // empty
    push_cmd(OP_QUERY,  11'd3,    32'd10);           // left past right
    push_cmd(OP_QUERY,  11'd2047, 32'd1024);         // empty after clamp
    push_cmd(OP_QUERY,  11'd0,    32'h7FFF_FFFF);
    push_cmd(OP_UPDATE, 11'd512,  32'd0);
    push_cmd(OP_QUERY,  11'd513,  32'd512);
    push_cmd(OP_RESERVED, 11'h7FF, 32'hFFFF_FFFF);
    push_cmd(OP_QUERY,  11'd1024, 32'd0);
    push_cmd(OP_CLEAR,  11'd0,    32'd0);
    push_cmd(OP_QUERY,  11'd1024, 32'd0);
    push_cmd(OP_UPDATE, 11'd0,    32'd7);
    push_cmd(OP_QUERY,  11'd1,    32'd0);

    while (cmd_q.size() < N_ITEMS) begin
      case ($urandom_range(0, 99))
        0: push_cmd(OP_CLEAR, 11'($urandom), $urandom);
        1, 2: push_cmd(OP_RESERVED, 11'($urandom), $urandom);
        3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 24,
        25, 26, 27, 28, 29, 30, 31, 32, 33, 34, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44,
        45, 46, 47:
          push_cmd(OP_UPDATE, pick_slot(), pick_value());
        default: begin
          case ($urandom_range(0, 19))
            0:       lft_bits = {1'b1, 31'($urandom)};
            1:       lft_bits = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1024, 4000);
            2, 3, 4: lft_bits = $urandom_range(0, 63);
            default: lft_bits = $urandom_range(0, LEAVES - 1);
          endcase
          lft = lft_bits[31] ? 0 : lft_bits[11:0];
          case ($urandom_range(0, 3))
            0:       rgt = lft + $urandom_range(0, 8);
            1:       rgt = lft + $urandom_range(0, 300);
            2:       rgt = $urandom_range(0, 2047);
            default: rgt = lft + $urandom_range(0, 64);
          endcase
          if (rgt > 2047) rgt = 2047;
          push_cmd(OP_QUERY, rgt[10:0], lft_bits);
        end
      endcase
    end
    n_total = cmd_q.size();

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_in != n_total) @(posedge clk_i);
    while (min_expect_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d updates, %0d queries, %0d clears, %0d reserved-op items",
             n_upd, n_qry, n_clr, n_rsv);
    $display("%0d results checked, %0d bad", n_out, n_bad);
    if (n_bad == 0) begin
      $display("range_minimum_segment_tree_core: match");
    end else begin
      $display("range_minimum_segment_tree_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rmst_pkg.sv
hw/rtl/rmst_node_ram.sv
hw/rtl/rmst_seq.sv
hw/rtl/range_minimum_segment_tree_core.sv
sim/range_minimum_segment_tree_core_tb.sv
